/* rtl/core/sjls_pkg.sv */
// ----------------------------------------------------------------------------
// sjls_pkg: shared types and constants of the Shift-JIS likelihood scorer
// Holds the status codes, the character classes, the per-class point table
// and the record that moves from the byte front end to the scoring back end.
// ----------------------------------------------------------------------------
package sjls_pkg;

  // Field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned POINT_W  = 7;
  localparam int unsigned TOTAL_W  = 27;
  localparam int unsigned COUNT_W  = 21;
  localparam int unsigned SCORE_W  = 7;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OUT_W    = 32;

  // Character limit per string
  localparam logic [COUNT_W-1:0] MAX_CHARS = COUNT_W'(1048576);

  // Queue between front and back (depth is a power of two)
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QLVL_W  = $clog2(QDEPTH + 1);

  // Divider: quotient never exceeds the largest point value
  localparam int unsigned QUOT_W  = 7;
  localparam int unsigned DEN_W   = TOTAL_W + 1;
  localparam logic [SCORE_W-1:0] SCORE_CAP = SCORE_W'(100);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_TOO_LONG = 2'd2
  } sjls_status_e;

  // Character classes
  localparam logic [CLASS_W-1:0] CLS_ASCII   = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_HALF    = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_SYM1    = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_KANA    = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_SYM2    = 3'd4;
  localparam logic [CLASS_W-1:0] CLS_KANJI1  = 3'd5;
  localparam logic [CLASS_W-1:0] CLS_KANJI2  = 3'd6;
  localparam logic [CLASS_W-1:0] CLS_NONE    = 3'd7;

  // Two-byte code boundaries
  localparam logic [15:0] CODE_SYM1_END  = 16'h824e;
  localparam logic [15:0] CODE_KANA_END  = 16'h8396;
  localparam logic [15:0] CODE_SYM2_END  = 16'h889e;
  localparam logic [15:0] CODE_LIMIT     = 16'heaa5;
  localparam logic [7:0]  LEAD_LEVEL1_END = 8'h9f;

  // Points by [own class][previous class]
  localparam logic [POINT_W-1:0] POINTS [0:6][0:7] = '{
    '{7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50, 7'd50},
    '{7'd49, 7'd51, 7'd50, 7'd50, 7'd40, 7'd50, 7'd40, 7'd50},
    '{7'd60, 7'd60, 7'd65, 7'd60, 7'd60, 7'd60, 7'd60, 7'd60},
    '{7'd60, 7'd51, 7'd60, 7'd65, 7'd55, 7'd60, 7'd60, 7'd60},
    '{7'd45, 7'd45, 7'd49, 7'd45, 7'd55, 7'd49, 7'd40, 7'd49},
    '{7'd55, 7'd50, 7'd60, 7'd65, 7'd40, 7'd65, 7'd60, 7'd60},
    '{7'd45, 7'd45, 7'd50, 7'd50, 7'd40, 7'd50, 7'd50, 7'd50}
  };

  // One finished string, handed from front to back
  typedef struct packed {
    sjls_status_e       status;
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
  } sjls_rec_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_DONE = 2'd2
  } sjls_back_state_e;

  // Point lookup; class 7 never occurs as own class
  function automatic logic [POINT_W-1:0] points_of(input logic [CLASS_W-1:0] cls,
                                                    input logic [CLASS_W-1:0] prev);
    logic [POINT_W-1:0] p;
    p = '0;
    if (cls != CLS_NONE) begin
      p = POINTS[cls][prev];
    end
    return p;
  endfunction

endpackage

/* rtl/core/sjls_front.sv */
// ----------------------------------------------------------------------------
// sjls_front: byte front end
// Classifies each byte, pairs lead and trail bytes, keeps the running point
// total and character count, and pushes one record at the end of a string.
// ----------------------------------------------------------------------------
module sjls_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [7:0]                 byte_i,
  input  logic                       last_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  output logic                       push_valid_o,
  input  logic                       push_ready_i,
  output sjls_pkg::sjls_rec_t        push_rec_o
);
  import sjls_pkg::*;

  logic [7:0]         lead_q, lead_d;
  logic               pend_q, pend_d;
  logic [CLASS_W-1:0] prev_q, prev_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] count_q, count_d;
  sjls_status_e       err_q, err_d;

  logic               tally_en;
  logic [CLASS_W-1:0] cls;
  logic [15:0]        code;
  logic               trail_ok;
  logic               fire;

  assign ready_o      = push_ready_i;
  assign fire         = valid_i & ready_o;
  assign push_valid_o = valid_i & last_i;
  assign code         = {lead_q, byte_i};
  assign trail_ok     = (byte_i inside {[8'h40:8'h7e], [8'h80:8'hfc]});

  // Classify byte and update the tally
  always_comb begin
    lead_d   = lead_q;
    pend_d   = pend_q;
    prev_d   = prev_q;
    total_d  = total_q;
    count_d  = count_q;
    err_d    = err_q;
    tally_en = 1'b0;
    cls      = CLS_ASCII;

    if (err_q == ST_OK) begin
      if (pend_q) begin
        pend_d = 1'b0;
        if (!trail_ok) begin
          err_d = ST_INVALID;
        end else if (code <= CODE_SYM1_END) begin
          cls = CLS_SYM1;   tally_en = 1'b1;
        end else if (code <= CODE_KANA_END) begin
          cls = CLS_KANA;   tally_en = 1'b1;
        end else if (code <= CODE_SYM2_END) begin
          cls = CLS_SYM2;   tally_en = 1'b1;
        end else if (lead_q <= LEAD_LEVEL1_END) begin
          cls = CLS_KANJI1; tally_en = 1'b1;
        end else if (code < CODE_LIMIT) begin
          cls = CLS_KANJI2; tally_en = 1'b1;
        end else begin
          err_d = ST_INVALID;
        end
      end else if (byte_i == 8'h00) begin
        err_d = ST_INVALID;
      end else if (byte_i <= 8'h7f) begin
        cls = CLS_ASCII; tally_en = 1'b1;
      end else if (byte_i inside {[8'ha1:8'hdf]}) begin
        cls = CLS_HALF;  tally_en = 1'b1;
      end else if (byte_i inside {[8'h81:8'h9f], [8'he0:8'hfc]}) begin
        lead_d = byte_i;
        pend_d = 1'b1;
      end else begin
        err_d = ST_INVALID;
      end
    end

    if (tally_en) begin
      if (count_q >= MAX_CHARS) begin
        err_d = ST_TOO_LONG;
      end else begin
        total_d = total_q + TOTAL_W'(points_of(cls, prev_q));
        count_d = count_q + COUNT_W'(1);
        prev_d  = cls;
      end
    end

    if (err_d != ST_OK) begin
      pend_d = 1'b0;
    end
  end

  // Record for the back end; a dangling lead byte is invalid
  always_comb begin
    push_rec_o.status = (err_d == ST_OK && pend_d) ? ST_INVALID : err_d;
    push_rec_o.total  = total_d;
    push_rec_o.count  = count_d;
  end

  // String state; cleared after the final byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= '0;
      pend_q  <= 1'b0;
      prev_q  <= CLS_NONE;
      total_q <= '0;
      count_q <= '0;
      err_q   <= ST_OK;
    end else if (fire) begin
      if (last_i) begin
        lead_q  <= '0;
        pend_q  <= 1'b0;
        prev_q  <= CLS_NONE;
        total_q <= '0;
        count_q <= '0;
        err_q   <= ST_OK;
      end else begin
        lead_q  <= lead_d;
        pend_q  <= pend_d;
        prev_q  <= prev_d;
        total_q <= total_d;
        count_q <= count_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

/* rtl/core/sjls_fifo.sv */
// ----------------------------------------------------------------------------
// sjls_fifo: record queue
// Short register queue that lets the front end and the back end stall
// independently of each other.
// ----------------------------------------------------------------------------
module sjls_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_valid_i,
  output logic                          push_ready_o,
  input  sjls_pkg::sjls_rec_t           push_rec_i,
  output logic                          pop_valid_o,
  input  logic                          pop_ready_i,
  output sjls_pkg::sjls_rec_t           pop_rec_o,
  output logic [sjls_pkg::QLVL_W-1:0]   level_o
);
  import sjls_pkg::*;

  sjls_rec_t          mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q;
  logic [QPTR_W-1:0]  rd_ptr_q;
  logic [QLVL_W-1:0]  level_q;
  logic               push;
  logic               pop;

  assign push_ready_o = (level_q != QLVL_W'(QDEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_rec_o    = mem_q[rd_ptr_q];
  assign level_o      = level_q;

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        level_q <= level_q + QLVL_W'(1);
      end else if (pop && !push) begin
        level_q <= level_q - QLVL_W'(1);
      end
    end
  end

endmodule

/* rtl/core/sjls_back.sv */
// ----------------------------------------------------------------------------
// sjls_back: scoring back end
// Divides the point total by the character count one quotient bit per cycle,
// forms the capped score and holds the result in an output register.
// ----------------------------------------------------------------------------
module sjls_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  sjls_pkg::sjls_rec_t           pop_rec_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sjls_pkg::OUT_W-1:0]    out_data_o
);
  import sjls_pkg::*;

  sjls_back_state_e      state_q, state_d;
  sjls_status_e          status_q;
  logic [COUNT_W-1:0]    count_q;
  logic [TOTAL_W-1:0]    rem_q, rem_d;
  logic [DEN_W-1:0]      den_q, den_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [2:0]            step_q, step_d;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_data_q;
  logic                  load_in;
  logic                  load_out;
  logic                  ge;
  logic [SCORE_W:0]      sum;
  logic [SCORE_W-1:0]    score;

  assign ge  = ({1'b0, rem_q} >= den_q);
  assign sum = {1'b0, quot_q} + (SCORE_W+1)'(1);

  // Capped score, zero for errors or empty strings
  always_comb begin
    score = '0;
    if (status_q == ST_OK && count_q != '0) begin
      score = (sum > {1'b0, SCORE_CAP}) ? SCORE_CAP : sum[SCORE_W-1:0];
    end
  end

  // Divider sequencer
  always_comb begin
    state_d  = state_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quot_d   = quot_q;
    step_d   = step_q;
    load_in  = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (pop_valid_i) begin
          load_in = 1'b1;
          rem_d   = pop_rec_i.total;
          den_d   = DEN_W'({pop_rec_i.count, {(QUOT_W-1){1'b0}}});
          quot_d  = '0;
          step_d  = '0;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (ge) begin
          rem_d = rem_q - den_q[TOTAL_W-1:0];
        end
        quot_d = {quot_q[QUOT_W-2:0], ge};
        den_d  = den_q >> 1;
        step_d = step_q + 3'd1;
        if (step_q == 3'(QUOT_W - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign pop_ready_o = load_in;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
    if (load_in) begin
      status_q <= pop_rec_i.status;
      count_q  <= pop_rec_i.count;
    end
    if (load_out) begin
      out_data_q <= OUT_W'({count_q, score, status_q});
    end
  end

endmodule

/* rtl/core/shift_jis_likelihood_scorer_core.sv */
// ----------------------------------------------------------------------------
// shift_jis_likelihood_scorer_core: Shift-JIS likelihood scorer
// Scores a byte string for how plausible it is as Shift-JIS text.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one byte per transfer on s_axis, tlast on the final byte
//   of a string. One byte is taken per cycle while the record queue has room.
//   Output stream: one transfer per string on m_axis with status, score in
//   hundredths and character count; non-final bytes give nothing.
//   The back end divides the point total by the count one quotient bit per
//   cycle (seven steps) and takes the next record only after loading the
//   result, so strings that arrive faster than they are scored can fill the
//   two-entry queue and stall the input.
//   Reset clears the string state, the queue and the output valid flag.
//   When the receiver stalls, the result holds in the output register, the
//   back end waits with the next result, and the queue absorbs up to two
//   more finished strings before s_axis_tready_o drops.
// ----------------------------------------------------------------------------
module shift_jis_likelihood_scorer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_value
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [1:0] status, [8:2] score_hundredths,
                                        // [29:9] char_count, [31:30] zero
);
  import sjls_pkg::*;

  logic              push_valid;
  logic              push_ready;
  sjls_rec_t         push_rec;
  logic              pop_valid;
  logic              pop_ready;
  sjls_rec_t         pop_rec;
  logic [QLVL_W-1:0] q_level;

  // Byte front end
  sjls_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .valid_i      (s_axis_tvalid_i),
    .ready_o      (s_axis_tready_o),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  // Record queue
  sjls_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_rec_i   (push_rec),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_rec_o    (pop_rec),
    .level_o      (q_level)
  );

  // Scoring back end
  sjls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_rec_i   (pop_rec),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

`ifndef NO_ASSERTIONS
  // Queue never overfills
  a_queue_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= QLVL_W'(QDEPTH))
    else $error("record queue over depth");

  // Input is refused only while the queue is full
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_level == QLVL_W'(QDEPTH))
    else $error("input stalled with queue room");

  // A failed string carries no score
  a_err_score: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != ST_OK |-> m_axis_tdata_o[8:2] == '0)
    else $error("score on a failed string");

  // Score stays within range and status is a defined code
  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[8:2] <= SCORE_CAP && m_axis_tdata_o[1:0] != 2'd3)
    else $error("result out of range");
`endif

endmodule
